/* sv/pra_pkg.sv */
// Package for the point rotation block: fixed-point constants, the CORDIC
// arctangent table and the item record carried down the pipeline.
// Used by pra_cordic, point_rotate_about_axis and the testbench; depends on nothing.
package pra_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int COORD_WIDTH   = 32;
   localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int SAT_W         = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   localparam int CORDIC_LAT = CORDIC_N + 3;
   localparam int MUL_LAT    = 4;
   localparam int PIPE_LAT   = CORDIC_LAT + 3 * MUL_LAT + 4;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

   localparam logic [5:0] SH_DOT  = 6'd16;
   localparam logic [5:0] SH_FRAC = 6'd30;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct {
      logic signed [31:0] p   [3];
      logic signed [31:0] d   [3];
      logic signed [32:0] v   [3];
      logic signed [33:0] c;
      logic signed [33:0] s;
      logic signed [63:0] dot;
      logic signed [63:0] cr  [3];
      logic signed [63:0] vc  [3];
      logic signed [63:0] cs  [3];
      logic signed [63:0] acc [3];
   } item_type;

endpackage

/* sv/pra_cordic.sv */
// Pipelined sine/cosine: angle range reduction, one CORDIC rotation per stage,
// quadrant sign fix. Depends on pra_pkg.
module pra_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] angle,
   output logic signed [33:0] cos_q30,
   output logic signed [33:0] sin_q30
);

   logic signed [35:0] a4;
   logic signed [35:0] wrap_in;
   logic signed [35:0] wrap_ff;
   logic signed [35:0] fold;
   logic               flip;

   logic signed [33:0] x_ff    [pra_pkg::CORDIC_N + 1];
   logic signed [33:0] y_ff    [pra_pkg::CORDIC_N + 1];
   logic signed [33:0] z_ff    [pra_pkg::CORDIC_N + 1];
   logic               flip_ff [pra_pkg::CORDIC_N + 1];

   always_comb begin
      a4 = 36'(angle) <<< 2;
      wrap_in = a4;
      if (a4 > pra_pkg::PI_Q30) begin
         wrap_in = a4 - pra_pkg::TWO_PI_Q30;
      end else if (a4 < -pra_pkg::PI_Q30) begin
         wrap_in = a4 + pra_pkg::TWO_PI_Q30;
      end
   end

   always_comb begin
      fold = wrap_ff;
      flip = 1'b0;
      if (wrap_ff > pra_pkg::HALF_PI_Q30) begin
         fold = wrap_ff - pra_pkg::PI_Q30;
         flip = 1'b1;
      end else if (wrap_ff < -pra_pkg::HALF_PI_Q30) begin
         fold = wrap_ff + pra_pkg::PI_Q30;
         flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wrap_ff    <= wrap_in;
         x_ff[0]    <= pra_pkg::GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= 34'(fold);
         flip_ff[0] <= flip;
      end
   end

   for (genvar i = 0; i < pra_pkg::CORDIC_N; i++) begin : g_stage
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = 34'(signed'(pra_pkg::ATAN_Q30[i]));
      always_ff @(posedge clock) begin
         if (en) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_q30 <= flip_ff[pra_pkg::CORDIC_N] ? -x_ff[pra_pkg::CORDIC_N]
                                               : x_ff[pra_pkg::CORDIC_N];
         sin_q30 <= flip_ff[pra_pkg::CORDIC_N] ? -y_ff[pra_pkg::CORDIC_N]
                                               : y_ff[pra_pkg::CORDIC_N];
      end
   end

endmodule

/* sv/pra_mulsh.sv */
// Four-stage signed multiply with rounded right shift (ties away from zero),
// built from four 32x32 partial products. Depends on nothing.
module pra_mulsh (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   input  logic        [5:0]  sh,
   output logic signed [63:0] p
);

   logic [2:0]   neg_ff;
   logic [63:0]  ua_ff;
   logic [63:0]  ub_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] full_ff;
   logic [127:0] rnd;
   logic [63:0]  q;
   logic [63:0]  qs;

   always_comb begin
      rnd = full_ff + (128'd1 << (sh - 6'd1));
      q   = 64'(rnd >> sh);
      qs  = q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : q;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= {neg_ff[1:0], a[63] ^ b[63]};
         ua_ff   <= a[63] ? 64'(-a) : 64'(a);
         ub_ff   <= b[63] ? 64'(-b) : 64'(b);
         p00_ff  <= ua_ff[31:0]  * ub_ff[31:0];
         p01_ff  <= ua_ff[31:0]  * ub_ff[63:32];
         p10_ff  <= ua_ff[63:32] * ub_ff[31:0];
         p11_ff  <= ua_ff[63:32] * ub_ff[63:32];
         full_ff <= {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0}
                  + {32'd0, p10_ff, 32'd0} + {p11_ff, 64'd0};
         p       <= neg_ff[2] ? -signed'(qs) : signed'(qs);
      end
   end

endmodule

/* sv/point_rotate_about_axis.sv */
// Rotates a Q16.16 point about an axis (Q2.30) through a pivot by an angle
// (Q4.28 radians) using Rodrigues' formula; the axis is not normalised.
// Takes one item per cycle while the output is not stalled; the pipeline depth is
// set by the CORDIC stage count and three chained 4-stage multipliers.
// The whole pipeline stalls only while a result waits on rsp_tready.
// Depends on pra_pkg, pra_cordic and pra_mulsh.
module point_rotate_about_axis (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x, vec_y, vec_z, pivot_x, pivot_y, pivot_z, axis_x, axis_y, axis_z, angle
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z
   output logic [95:0]  rsp_tdata,
   // overflow
   output logic [0:0]   rsp_tuser
);

   localparam int LC = pra_pkg::CORDIC_LAT;
   localparam int LM = pra_pkg::MUL_LAT;
   localparam int LT = pra_pkg::PIPE_LAT;

   logic          en;
   logic [LT-1:0] vld_ff;

   pra_pkg::item_type in_item;
   pra_pkg::item_type a_ff [LC];
   pra_pkg::item_type b_ff [LM];
   pra_pkg::item_type p_ff;
   pra_pkg::item_type m_ff [LM];
   pra_pkg::item_type n_ff [LM];
   pra_pkg::item_type f1_ff;
   pra_pkg::item_type b_in;
   pra_pkg::item_type p_in;
   pra_pkg::item_type n_in;
   pra_pkg::item_type f1_in;
   logic signed [63:0] rnd_ff [3];
   logic signed [31:0] piv_ff [3];

   logic signed [33:0] cos_q30, sin_q30;
   logic signed [63:0] m1_dv [3], m1_jk [3], m1_kj [3], m1_vc [3];
   logic signed [63:0] m2_td [3], m2_cs [3], m3_tm [3];
   logic signed [63:0] omc;

   logic signed [63:0] r_in   [3];
   logic signed [31:0] out_in [3];
   logic [2:0]         ovf_in;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LT-1];

   always_comb begin
      in_item = a_ff[0];
      for (int i = 0; i < 3; i++) begin
         in_item.p[i] = signed'(req_tdata[96 + 32*i +: 32]);
         in_item.d[i] = signed'(req_tdata[192 + 32*i +: 32]);
         in_item.v[i] = 33'(signed'(req_tdata[32*i +: 32])) - 33'(in_item.p[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LT-2:0], req_tvalid};
      end
   end

   pra_cordic u_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (signed'(req_tdata[319:288])),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      pra_mulsh u_dv (.clock(clock), .en(en), .a(64'(a_ff[LC-1].d[i])),
                      .b(64'(a_ff[LC-1].v[i])), .sh(pra_pkg::SH_DOT), .p(m1_dv[i]));
      pra_mulsh u_jk (.clock(clock), .en(en), .a(64'(a_ff[LC-1].d[J])),
                      .b(64'(a_ff[LC-1].v[K])), .sh(pra_pkg::SH_DOT), .p(m1_jk[i]));
      pra_mulsh u_kj (.clock(clock), .en(en), .a(64'(a_ff[LC-1].d[K])),
                      .b(64'(a_ff[LC-1].v[J])), .sh(pra_pkg::SH_DOT), .p(m1_kj[i]));
      pra_mulsh u_vc (.clock(clock), .en(en), .a(64'(a_ff[LC-1].v[i])),
                      .b(64'(cos_q30)), .sh(pra_pkg::SH_DOT), .p(m1_vc[i]));

      pra_mulsh u_td (.clock(clock), .en(en), .a(64'(p_ff.d[i])),
                      .b(p_ff.dot), .sh(pra_pkg::SH_FRAC), .p(m2_td[i]));
      pra_mulsh u_cs (.clock(clock), .en(en), .a(p_ff.cr[i]),
                      .b(64'(p_ff.s)), .sh(pra_pkg::SH_FRAC), .p(m2_cs[i]));

      pra_mulsh u_tm (.clock(clock), .en(en), .a(m2_td[i]),
                      .b(omc), .sh(pra_pkg::SH_FRAC), .p(m3_tm[i]));
   end

   assign omc = pra_pkg::ONE_Q30 - 64'(m_ff[LM-1].c);

   always_comb begin
      b_in   = a_ff[LC-1];
      b_in.c = cos_q30;
      b_in.s = sin_q30;

      p_in     = b_ff[LM-1];
      p_in.dot = m1_dv[0] + m1_dv[1] + m1_dv[2];
      for (int i = 0; i < 3; i++) begin
         p_in.cr[i] = m1_jk[i] - m1_kj[i];
         p_in.vc[i] = m1_vc[i];
      end

      n_in = m_ff[LM-1];
      for (int i = 0; i < 3; i++) begin
         n_in.cs[i] = m2_cs[i];
      end

      f1_in = n_ff[LM-1];
      for (int i = 0; i < 3; i++) begin
         f1_in.acc[i] = n_ff[LM-1].vc[i] + n_ff[LM-1].cs[i] + m3_tm[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_in[i]   = rnd_ff[i] + 64'(piv_ff[i]);
         ovf_in[i] = (r_in[i] > pra_pkg::SAT_HI) || (r_in[i] < pra_pkg::SAT_LO);
         if (r_in[i] > pra_pkg::SAT_HI) begin
            out_in[i] = pra_pkg::SAT_HI[31:0];
         end else if (r_in[i] < pra_pkg::SAT_LO) begin
            out_in[i] = pra_pkg::SAT_LO[31:0];
         end else begin
            out_in[i] = r_in[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [63:0] mag;
      logic [63:0] q;
      if (en) begin
         a_ff[0] <= in_item;
         for (int k = 1; k < LC; k++) begin
            a_ff[k] <= a_ff[k-1];
         end

         b_ff[0] <= b_in;
         for (int k = 1; k < LM; k++) begin
            b_ff[k] <= b_ff[k-1];
         end

         p_ff <= p_in;

         m_ff[0] <= p_ff;
         for (int k = 1; k < LM; k++) begin
            m_ff[k] <= m_ff[k-1];
         end

         n_ff[0] <= n_in;
         for (int k = 1; k < LM; k++) begin
            n_ff[k] <= n_ff[k-1];
         end

         f1_ff <= f1_in;

         for (int i = 0; i < 3; i++) begin
            mag       = f1_ff.acc[i][63] ? 64'(-f1_ff.acc[i]) : 64'(f1_ff.acc[i]);
            q         = (mag + 64'd8192) >> 14;
            rnd_ff[i] <= f1_ff.acc[i][63] ? -signed'(q) : signed'(q);
            piv_ff[i] <= f1_ff.p[i];
         end

         rsp_tdata <= {out_in[2], out_in[1], out_in[0]};
         rsp_tuser <= |ovf_in;
      end
   end

   property p_stall_holds;
      @(posedge clock) disable iff (reset) !en |=> vld_ff == $past(vld_ff);
   endproperty
   a_stall_holds : assert property (p_stall_holds)
      else $error("pipeline valid bits moved during stall");

   property p_accept_enters;
      @(posedge clock) disable iff (reset) req_tvalid && req_tready |=> vld_ff[0];
   endproperty
   a_accept_enters : assert property (p_accept_enters)
      else $error("accepted item not entered in pipeline");

   property p_ovf_rail;
      @(posedge clock) disable iff (reset) rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[31:0]  == pra_pkg::SAT_HI[31:0]) ||
         (rsp_tdata[31:0]  == pra_pkg::SAT_LO[31:0]) ||
         (rsp_tdata[63:32] == pra_pkg::SAT_HI[31:0]) ||
         (rsp_tdata[63:32] == pra_pkg::SAT_LO[31:0]) ||
         (rsp_tdata[95:64] == pra_pkg::SAT_HI[31:0]) ||
         (rsp_tdata[95:64] == pra_pkg::SAT_LO[31:0]);
   endproperty
   a_ovf_rail : assert property (p_ovf_rail)
      else $error("overflow set with no component at a rail");

endmodule

/* tb/testbench.sv */
// Testbench for point_rotate_about_axis: drives points, pivots, axes and angles,
// predicts each rotated point with a local fixed-point Rodrigues/CORDIC model.
// Depends on pra_pkg and the point_rotate_about_axis RTL.
module testbench;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic               ovf;
   } rot_result_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [319:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   rot_result_type expected_points[$];
   int  mismatches = 0;
   int  points_sent = 0;
   int  points_checked = 0;
   bit  send_idle_on = 1;
   bit  recv_idle_on = 1;
   bit  recv_hold_on = 0;

   point_rotate_about_axis dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [63:0] round_shift(logic signed [63:0] a,
                                                      logic signed [63:0] b, int k);
      logic         neg;
      logic [63:0]  ua, ub;
      logic [127:0] prod, q;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? -a : a;
      ub   = (b < 0) ? -b : b;
      prod = ua * ub;
      q    = (prod + (128'd1 << (k - 1))) >> k;
      q    = {64'd0, q[63:0]};
      if (q > 128'h7FFFFFFFFFFFFFFF) q = 128'h7FFFFFFFFFFFFFFF;
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int k);
      return v >>> k;
   endfunction

   function automatic void cordic_sincos(logic signed [63:0] a,
                                         output logic signed [63:0] c,
                                         output logic signed [63:0] s);
      logic signed [63:0] x, y, z, dx, dy;
      logic flip;
      x = pra_pkg::GAIN_Q30; y = 0; flip = 0;
      if (a > pra_pkg::PI_Q30) a -= pra_pkg::TWO_PI_Q30;
      if (a < -pra_pkg::PI_Q30) a += pra_pkg::TWO_PI_Q30;
      if (a > pra_pkg::HALF_PI_Q30) begin
         a -= pra_pkg::PI_Q30; flip = 1;
      end else if (a < -pra_pkg::HALF_PI_Q30) begin
         a += pra_pkg::PI_Q30; flip = 1;
      end
      z = a;
      for (int i = 0; i < pra_pkg::CORDIC_N; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= $signed({32'd0, pra_pkg::ATAN_Q30[i]});
         end else begin
            x += dx; y -= dy; z += $signed({32'd0, pra_pkg::ATAN_Q30[i]});
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic rot_result_type rotate_point(logic [319:0] item);
      logic signed [63:0] v[3], p[3], d[3], r[3];
      logic signed [63:0] c, s, omc, dot, cr, acc;
      rot_result_type res;
      int j, k;
      res.ovf = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = $signed(item[32*(3+i) +: 32]);
         v[i] = $signed(item[32*i +: 32]) - p[i];
         d[i] = $signed(item[32*(6+i) +: 32]);
      end
      cordic_sincos($signed(item[288 +: 32]) * 64'sd4, c, s);
      omc = pra_pkg::ONE_Q30 - c;
      for (int i = 0; i < 3; i++) dot += round_shift(d[i], v[i], 16);
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         cr  = round_shift(d[j], v[k], 16) - round_shift(d[k], v[j], 16);
         acc = round_shift(v[i], c, 16) + round_shift(cr, s, 30)
               + round_shift(round_shift(d[i], dot, 30), omc, 30);
         r[i] = round_shift(acc, 1, 14) + p[i];
         if (r[i] > pra_pkg::SAT_HI) begin
            r[i] = pra_pkg::SAT_HI; res.ovf = 1;
         end
         if (r[i] < pra_pkg::SAT_LO) begin
            r[i] = pra_pkg::SAT_LO; res.ovf = 1;
         end
      end
      res.x = r[0][31:0];
      res.y = r[1][31:0];
      res.z = r[2][31:0];
      return res;
   endfunction

   // Valid stays high between items unless the sender idles or stops
   task automatic send_point(logic [319:0] item);
      while (send_idle_on && $urandom_range(99) < 15) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
      expected_points.push_back(rotate_point(item));
      points_sent++;
   endtask

   // Result checker
   always @(posedge clock) begin
      rot_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_checked++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            e = expected_points.pop_front();
            if (rsp_tdata !== {e.z, e.y, e.x} || rsp_tuser[0] !== e.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h ovf %b, got %h ovf %b",
                           {e.z, e.y, e.x}, e.ovf, rsp_tdata, rsp_tuser[0]);
            end
         end
      end
   end

   // Receiver readiness with random idling
   always @(posedge clock) begin
      rsp_tready <= !recv_hold_on && !(recv_idle_on && $urandom_range(99) < 15);
   end

   function automatic logic [31:0] edge_word(int sel);
      case (sel)
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'h0;
         3: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [319:0] random_point(bit small_range);
      logic [319:0] item;
      logic [31:0]  w;
      for (int f = 0; f < 10; f++) begin
         w = $urandom;
         if (small_range && f < 6) w = $signed(w) >>> $urandom_range(14);
         if (small_range && f >= 6 && f < 9) w = $signed(w) >>> $urandom_range(1, 4);
         if ($urandom_range(19) == 0) w = edge_word($urandom_range(3));
         item[32*f +: 32] = w;
      end
      return item;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [319:0] item;
      logic [31:0]  angles[8] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h3243F6A9,
                                  32'hCDBC0957, 32'h1921FB54, 32'h6487ED51, 32'h10000000};
      foreach (angles[a]) begin
         item = '0;
         item[31:0] = 32'h00010000; item[95:64] = 32'h00020000;
         item[224 +: 32] = 32'h40000000;
         item[288 +: 32] = angles[a];
         send_point(item);
      end
      item = '0;
      item[31:0] = 32'h00050000; item[127:96] = 32'h00010000;
      item[288 +: 32] = 32'h10000000;
      send_point(item);
      for (int e = 0; e < 4; e++) begin
         for (int f = 0; f < 10; f++) item[32*f +: 32] = edge_word(e);
         send_point(item);
      end
      for (int e = 0; e < 6; e++) begin
         for (int f = 0; f < 10; f++) item[32*f +: 32] = edge_word($urandom_range(3));
         send_point(item);
      end
      item = '0;
      item[192 +: 32] = 32'h7FFFFFFF; item[224 +: 32] = 32'h7FFFFFFF;
      item[31:0] = 32'h7FFFFFFF; item[63:32] = 32'h80000000;
      item[288 +: 32] = 32'h1921FB54;
      send_point(item);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) send_point(random_point($urandom_range(3) != 0));
   endtask

   task automatic test_no_idle(int count);
      send_idle_on = 0; recv_idle_on = 0;
      test_random(count);
      send_idle_on = 1; recv_idle_on = 1;
   endtask

   task automatic test_backpressure();
      fork
         begin
            recv_hold_on = 1;
            repeat (200) @(posedge clock);
            recv_hold_on = 0;
         end
         test_random(120);
      join
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      test_directed();
      wait_drained();
      test_random(500);
      test_no_idle(300);
      test_backpressure();
      test_random(450);
      wait_drained();
      repeat (pra_pkg::PIPE_LAT + 20) @(posedge clock);
      $display("covered %0d rotations (%0d checked): edge values, angle wrap, zero axis,",
               points_sent, points_checked);
      $display("overflow saturation, back-pressure and idle gaps");
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

/* filelist.f */
sv/pra_pkg.sv
sv/pra_cordic.sv
sv/pra_mulsh.sv
sv/point_rotate_about_axis.sv
tb/testbench.sv
